// File: rtl/tcpq_pkg.sv
`timescale 1ns / 1ps

package tcpq_pkg;

    // Default sizes
    localparam int DEPTH_DEF        = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Field widths fixed by the request format
    localparam int CLASS_W     = 2;
    localparam int STATUS_W    = 2;
    localparam int NUM_CLASSES = 3;

    // Request kinds
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Urgency classes, most urgent first
    localparam logic [CLASS_W-1:0] CLS_INSTANT  = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_STANDARD = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_ECONOMY  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Per-class queue control
    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

endpackage

// File: rtl/tcpq_ram.sv
`timescale 1ns / 1ps

module tcpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word with registered data (old value on collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tcpq_class_fifo.sv
`timescale 1ns / 1ps

module tcpq_class_fifo #(
    parameter int DEPTH = tcpq_pkg::DEPTH_DEF,
    parameter int WIDTH = tcpq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcpq_pkg::t_fifo_ctl i_ctl,
    input  logic [WIDTH-1:0]    i_data,
    output logic [WIDTH-1:0]    o_front,
    output logic                o_empty
);

    import tcpq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_tail, n_tail;
    logic [CW-1:0]    r_count, n_count;
    logic             r_byp_hit;
    logic [WIDTH-1:0] r_byp_data;
    logic [WIDTH-1:0] w_rdata;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Advance pointers and count
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctl.push) begin
            n_tail  = ptr_inc(r_tail);
            n_count = r_count + 1'b1;
        end else if (i_ctl.pop) begin
            n_head  = ptr_inc(r_head);
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_byp_hit <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_byp_hit <= i_ctl.push && (r_tail == n_head);
        end
        r_byp_data <= i_data;
    end

    // Read the next front ahead; the RAM port is read-old on collision
    tcpq_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.push),
        .i_waddr (r_tail),
        .i_wdata (i_data),
        .i_raddr (n_head),
        .o_rdata (w_rdata)
    );

    // Bypass a word written straight into the front slot
    assign o_front = r_byp_hit ? r_byp_data : w_rdata;
    assign o_empty = (r_count == '0);

endmodule

// File: rtl/three_class_priority_queue.sv
`timescale 1ns / 1ps

// Three-class stable priority queue. A request (push or pop) is taken at any
// clock edge with start high and busy low; busy is high only while reset is
// held and for the edge that releases it. One request is taken every cycle,
// and its result appears on the o_ ports with o_valid high for exactly one
// cycle, after the input register and a pass through the per-class queue
// logic into the result register. Results cannot be held off, so the
// receiver must take every o_valid cycle. Each class keeps its own circular
// queue in a RAM with a registered read; the next front entry is fetched
// ahead, with a bypass for a word pushed into an empty class, so back-to-back
// pops of one class run at full rate. The pool is shared: a push fails once
// DEPTH entries are held in total. No clearing pass is needed after reset.
module three_class_priority_queue #(
    parameter int DEPTH        = tcpq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = tcpq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_kind,
    input  logic [tcpq_pkg::CLASS_W-1:0]     i_urgency,
    input  logic [PAYLOAD_BITS-1:0]          i_payload,
    output logic                             o_valid,
    output logic [tcpq_pkg::STATUS_W-1:0]    o_status,
    output logic [PAYLOAD_BITS-1:0]          o_popped_payload,
    output logic [tcpq_pkg::CLASS_W-1:0]     o_popped_class,
    output logic [$clog2(DEPTH + 1)-1:0]     o_occupancy
);

    import tcpq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic                    r_busy;
    logic                    r_req_valid;
    logic                    r_kind;
    logic [CLASS_W-1:0]      r_urgency;
    logic [PAYLOAD_BITS-1:0] r_payload;

    logic [CW-1:0]           r_total, n_total;
    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_status, n_status;
    logic [PAYLOAD_BITS-1:0] r_pop_word, n_pop_word;
    logic [CLASS_W-1:0]      r_pop_cls, n_pop_cls;

    t_fifo_ctl               w_ctl   [NUM_CLASSES];
    logic [PAYLOAD_BITS-1:0] w_front [NUM_CLASSES];
    logic [NUM_CLASSES-1:0]  w_empty;
    logic [CLASS_W-1:0]      w_push_cls;
    logic [CLASS_W-1:0]      w_sel;
    logic                    w_has;

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b1;
            r_req_valid <= 1'b0;
        end else begin
            r_busy      <= 1'b0;
            r_req_valid <= start && !r_busy;
        end
        r_kind    <= i_kind;
        r_urgency <= i_urgency;
        r_payload <= i_payload;
    end

    assign busy = r_busy;

    // Fold the unused urgency code into economy
    assign w_push_cls = (r_urgency > CLS_ECONOMY) ? CLS_ECONOMY : r_urgency;

    // Find the most urgent class that holds an entry
    always_comb begin
        w_has = 1'b0;
        w_sel = CLS_INSTANT;
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if (!w_empty[i]) begin
                w_has = 1'b1;
                w_sel = CLASS_W'(i);
            end
        end
    end

    // Execute the request against the class queues
    always_comb begin
        for (int i = 0; i < NUM_CLASSES; i++) begin
            w_ctl[i] = '0;
        end
        n_total    = r_total;
        n_status   = ST_OK;
        n_pop_word = '0;
        n_pop_cls  = CLS_INSTANT;
        if (r_req_valid) begin
            if (r_kind == KIND_PUSH) begin
                if (r_total == CW'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl[w_push_cls].push = 1'b1;
                    n_total = r_total + 1'b1;
                end
            end else begin
                if (!w_has) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ctl[w_sel].pop = 1'b1;
                    n_pop_word = w_front[w_sel];
                    n_pop_cls  = w_sel;
                    n_total    = r_total - 1'b1;
                end
            end
        end
    end

    // One queue per class
    for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_class
        tcpq_class_fifo #(
            .DEPTH (DEPTH),
            .WIDTH (PAYLOAD_BITS)
        ) u_fifo (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_data  (r_payload),
            .o_front (w_front[g]),
            .o_empty (w_empty[g])
        );
    end

    // Register the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_total     <= n_total;
            r_out_valid <= r_req_valid;
        end
        r_status   <= n_status;
        r_pop_word <= n_pop_word;
        r_pop_cls  <= n_pop_cls;
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_popped_payload = r_pop_word;
    assign o_popped_class   = r_pop_cls;
    assign o_occupancy      = r_total;

endmodule
